// ===== sv/iat_pkg.sv =====
// Shared types and constants for the indexed array table.
// Used by iat_cmp, iat_core and the indexed_array_table top level.
package iat_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = 4;
	localparam int CNT_W = 5;
	localparam int POS_W = 5;
	localparam int VAL_W = 32;

	typedef enum logic [2:0] {
		CMD_INSERT  = 3'd0,
		CMD_DELETE  = 3'd1,
		CMD_UPDATE  = 3'd2,
		CMD_SEARCH  = 3'd3,
		CMD_SORT    = 3'd4,
		CMD_READOUT = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		ST_DONE   = 3'd0,
		ST_MISS   = 3'd1,
		ST_REJECT = 3'd2,
		ST_ENTRY  = 3'd3,
		ST_EMPTY  = 3'd4
	} status_t;

	typedef struct packed {
		logic eq;
		logic lt;
	} cmp_t;

	typedef struct packed {
		status_t           status;
		logic [IDX_W-1:0]  found_index;
		logic [VAL_W-1:0]  entry_value;
		logic [CNT_W-1:0]  entry_count;
		logic              last;
	} res_t;

endpackage

// ===== sv/indexed_array_table.sv =====
// Indexed array table: an ordered list of up to 16 signed 32-bit entries
// kept in a small memory and worked on by one sequencer and one comparator.
//
// Commands arrive on the s_ channel (command in s_tuser, position and value
// in s_tdata); results leave on the m_ channel with the status in m_tuser
// and m_tlast on the final result of each command. One command is taken at
// a time: s_tready is high only while the sequencer is idle.
// Each command is worked step by step on the memory: an update writes the
// entry straight from idle; an insert shifts the entries from the end down
// to the position, then writes the new value; a delete shifts the entries
// above the position down by one place; a search examines entries from the
// front until one equals the key; the sort compares every pair (i, j) with
// i < j and swaps them when entry j is less; a readout gives one result per
// entry.
// The memory has one write port, so every shift step is a read then a write.
// Results pass through a one-deep output register, so the sequencer can
// finish while the previous result waits; a stalled receiver holds m_ data
// steady and, once that register is full, holds the sequencer as well.
// Reset empties the list; entry contents are not cleared.
module indexed_array_table
	import iat_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // position [4:0], value [36:5], zero [39:37]
	input  logic [2:0]  s_tuser,   // command [2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // found_index [3:0], entry_value [35:4],
	                               // entry_count [40:36], zero [47:41]
	output logic [2:0]  m_tuser,   // status [2:0]
	output logic        m_tlast
);

	logic res_valid;
	logic res_ready;
	res_t res;
	res_t out_q;
	logic out_valid_q;

	iat_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (s_tuser),
		.in_pos    (s_tdata[POS_W-1:0]),
		.in_val    (s_tdata[POS_W+VAL_W-1:POS_W]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// The output register takes a new result whenever it is empty or its
	// current contents are being transferred out in this cycle.
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = 3'(out_q.status);
	assign m_tlast  = out_q.last;
	assign m_tdata  = {7'd0, out_q.entry_count, out_q.entry_value, out_q.found_index};

endmodule

// ===== sv/iat_cmp.sv =====
// Shared comparator for the indexed array table: equality and signed less-than.
// Depends on iat_pkg for the value width and the result struct.
module iat_cmp
	import iat_pkg::*;
(
	input  logic signed [VAL_W-1:0] a,
	input  logic signed [VAL_W-1:0] b,
	output cmp_t                    res
);

	assign res.eq = (a == b);
	assign res.lt = (a < b);

endmodule

// ===== sv/iat_core.sv =====
// Command sequencer and entry memory of the indexed array table.
// Depends on iat_pkg and drives one shared iat_cmp comparator.
module iat_core
	import iat_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [2:0]              in_cmd,
	input  logic [POS_W-1:0]        in_pos,
	input  logic [VAL_W-1:0]        in_val,
	output logic                    res_valid,
	input  logic                    res_ready,
	output res_t                    res
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_LOOP,
		S_INS_WR,
		S_DEL_LOOP,
		S_DEL_WR,
		S_SRCH_LOOP,
		S_SRCH_CHK,
		S_SORT_LOOP,
		S_SORT_CMP,
		S_SORT_SWP,
		S_RDO_LOOP,
		S_RDO_OUT,
		S_RESP
	} state_t;

	state_t              state_q;
	logic [POS_W-1:0]    pos_q;
	logic [VAL_W-1:0]    val_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    i_q;
	logic [CNT_W-1:0]    j_q;
	status_t             status_q;
	logic [IDX_W-1:0]    idx_q;
	logic [VAL_W-1:0]    rval_q;

	logic [VAL_W-1:0]    mem [DEPTH];
	logic [VAL_W-1:0]    rd_a_q;
	logic [VAL_W-1:0]    rd_b_q;

	logic                we;
	logic [IDX_W-1:0]    wa;
	logic [VAL_W-1:0]    wd;
	logic                rd_en;
	logic [IDX_W-1:0]    ra;
	logic [IDX_W-1:0]    rb;

	logic [CNT_W-1:0]    i_inc;
	logic [CNT_W-1:0]    i_dec;
	logic [CNT_W-1:0]    pos_ext;
	logic                full;
	logic                pos_in_range;
	logic                pos_ins_ok;
	logic [VAL_W-1:0]    cmp_a;
	logic [VAL_W-1:0]    cmp_b;
	cmp_t                cmp;

	assign i_inc        = i_q + CNT_W'(1);
	assign i_dec        = i_q - CNT_W'(1);
	assign pos_ext      = CNT_W'(in_pos);
	assign full         = (count_q == CNT_W'(DEPTH));
	assign pos_in_range = (pos_ext < count_q);
	assign pos_ins_ok   = !full && (pos_ext <= count_q);

	// During the sort the pair is compared as (entry j < entry i); a search
	// compares the fetched entry against the key.
	assign cmp_a = (state_q == S_SORT_CMP) ? rd_b_q : rd_a_q;
	assign cmp_b = (state_q == S_SORT_CMP) ? rd_a_q : val_q;

	iat_cmp u_cmp (
		.a   (cmp_a),
		.b   (cmp_b),
		.res (cmp)
	);

	always_comb begin
		we    = 1'b0;
		wa    = i_q[IDX_W-1:0];
		wd    = rd_a_q;
		rd_en = 1'b0;
		ra    = i_q[IDX_W-1:0];
		rb    = j_q[IDX_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && in_cmd == CMD_UPDATE && pos_in_range) begin
					we = 1'b1;
					wa = in_pos[IDX_W-1:0];
					wd = in_val;
				end
			end
			S_INS_LOOP: begin
				if (i_q > pos_q) begin
					rd_en = 1'b1;
					ra    = i_dec[IDX_W-1:0];
				end else begin
					we = 1'b1;
					wa = pos_q[IDX_W-1:0];
					wd = val_q;
				end
			end
			S_INS_WR: begin
				we = 1'b1;
			end
			S_DEL_LOOP: begin
				rd_en = 1'b1;
				ra    = i_inc[IDX_W-1:0];
			end
			S_DEL_WR: begin
				we = 1'b1;
			end
			S_SRCH_LOOP, S_RDO_LOOP: begin
				rd_en = 1'b1;
			end
			S_SORT_LOOP: begin
				rd_en = (i_q < count_q) && (j_q < count_q);
			end
			S_SORT_CMP: begin
				if (cmp.lt) begin
					we = 1'b1;
					wd = rd_b_q;
				end
			end
			S_SORT_SWP: begin
				we = 1'b1;
				wa = j_q[IDX_W-1:0];
			end
			S_SRCH_CHK, S_RDO_OUT, S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rd_a_q <= mem[ra];
			rd_b_q <= mem[rb];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			pos_q    <= '0;
			val_q    <= '0;
			i_q      <= '0;
			j_q      <= '0;
			status_q <= ST_DONE;
			idx_q    <= '0;
			rval_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						pos_q  <= in_pos;
						val_q  <= in_val;
						idx_q  <= '0;
						rval_q <= '0;
						i_q    <= '0;
						j_q    <= CNT_W'(1);
						case (in_cmd)
							CMD_INSERT: begin
								if (pos_ins_ok) begin
									i_q     <= count_q;
									state_q <= S_INS_LOOP;
								end else begin
									status_q <= ST_REJECT;
									state_q  <= S_RESP;
								end
							end
							CMD_DELETE: begin
								if (pos_in_range) begin
									i_q     <= pos_ext;
									state_q <= S_DEL_LOOP;
								end else begin
									status_q <= ST_REJECT;
									state_q  <= S_RESP;
								end
							end
							CMD_UPDATE: begin
								status_q <= pos_in_range ? ST_DONE : ST_REJECT;
								state_q  <= S_RESP;
							end
							CMD_SEARCH: begin
								state_q <= S_SRCH_LOOP;
							end
							CMD_SORT: begin
								state_q <= S_SORT_LOOP;
							end
							CMD_READOUT: begin
								if (count_q == '0) begin
									status_q <= ST_EMPTY;
									state_q  <= S_RESP;
								end else begin
									state_q <= S_RDO_LOOP;
								end
							end
							default: begin
								status_q <= ST_REJECT;
								state_q  <= S_RESP;
							end
						endcase
					end
				end
				S_INS_LOOP: begin
					if (i_q > pos_q) begin
						state_q <= S_INS_WR;
					end else begin
						count_q  <= count_q + CNT_W'(1);
						status_q <= ST_DONE;
						state_q  <= S_RESP;
					end
				end
				S_INS_WR: begin
					i_q     <= i_dec;
					state_q <= S_INS_LOOP;
				end
				S_DEL_LOOP: begin
					if (i_inc < count_q) begin
						state_q <= S_DEL_WR;
					end else begin
						count_q  <= count_q - CNT_W'(1);
						status_q <= ST_DONE;
						state_q  <= S_RESP;
					end
				end
				S_DEL_WR: begin
					i_q     <= i_inc;
					state_q <= S_DEL_LOOP;
				end
				S_SRCH_LOOP: begin
					if (i_q < count_q) begin
						state_q <= S_SRCH_CHK;
					end else begin
						status_q <= ST_MISS;
						state_q  <= S_RESP;
					end
				end
				S_SRCH_CHK: begin
					if (cmp.eq) begin
						status_q <= ST_DONE;
						idx_q    <= i_q[IDX_W-1:0];
						rval_q   <= rd_a_q;
						state_q  <= S_RESP;
					end else begin
						i_q     <= i_inc;
						state_q <= S_SRCH_LOOP;
					end
				end
				S_SORT_LOOP: begin
					if (i_q < count_q) begin
						if (j_q < count_q) begin
							state_q <= S_SORT_CMP;
						end else begin
							i_q <= i_inc;
							j_q <= i_q + CNT_W'(2);
						end
					end else begin
						status_q <= ST_DONE;
						state_q  <= S_RESP;
					end
				end
				S_SORT_CMP: begin
					if (cmp.lt) begin
						state_q <= S_SORT_SWP;
					end else begin
						j_q     <= j_q + CNT_W'(1);
						state_q <= S_SORT_LOOP;
					end
				end
				S_SORT_SWP: begin
					j_q     <= j_q + CNT_W'(1);
					state_q <= S_SORT_LOOP;
				end
				S_RDO_LOOP: begin
					state_q <= S_RDO_OUT;
				end
				S_RDO_OUT: begin
					if (res_ready) begin
						if (i_inc == count_q) begin
							state_q <= S_IDLE;
						end else begin
							i_q     <= i_inc;
							state_q <= S_RDO_LOOP;
						end
					end
				end
				S_RESP: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_RESP) || (state_q == S_RDO_OUT);

	always_comb begin
		if (state_q == S_RDO_OUT) begin
			res.status      = ST_ENTRY;
			res.found_index = i_q[IDX_W-1:0];
			res.entry_value = rd_a_q;
			res.last        = (i_inc == count_q);
		end else begin
			res.status      = status_q;
			res.found_index = idx_q;
			res.entry_value = rval_q;
			res.last        = 1'b1;
		end
		res.entry_count = count_q;
	end

endmodule

// ===== tb/iat_checker.sv =====
// Checker for the indexed array table: watches both stream channels, keeps its own copy
// of the list, predicts the results of every command and compares them on arrival.
// Depends on iat_pkg for the command and status codes and the result layout.
module iat_checker
	import iat_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,   // position [4:0], value [36:5], zero [39:37]
	input  logic [2:0]  s_tuser,   // command [2:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,   // found_index [3:0], entry_value [35:4],
	                               // entry_count [40:36], zero [47:41]
	input  logic [2:0]  m_tuser,   // status [2:0]
	input  logic        m_tlast,
	output int          errors,
	output int          pending,
	output int          checked
);

	logic [VAL_W-1:0] list_copy [DEPTH];
	logic [CNT_W-1:0] list_len = '0;
	res_t             awaited_results [$];
	int               fail_count = 0;
	int               awaited_count = 0;
	int               result_count = 0;

	assign errors  = fail_count;
	assign pending = awaited_count;
	assign checked = result_count;

	task automatic await_result(status_t st, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] v,
			logic fin);
		res_t r;
		r.status      = st;
		r.found_index = idx;
		r.entry_value = v;
		r.entry_count = list_len;
		r.last        = fin;
		awaited_results.push_back(r);
	endtask

	// Applies one command to the local copy of the list and queues what it must produce.
	task automatic predict_table_op(logic [2:0] op, logic [POS_W-1:0] pos,
			logic [VAL_W-1:0] v);
		int i;
		int j;
		int hit;
		logic [VAL_W-1:0] t;
		hit = -1;
		case (op)
		CMD_INSERT: begin
			if (list_len >= DEPTH || pos > list_len) begin
				await_result(ST_REJECT, '0, '0, 1'b1);
			end else begin
				for (i = list_len; i > pos; i--)
					list_copy[i] = list_copy[i-1];
				list_copy[pos] = v;
				list_len++;
				await_result(ST_DONE, '0, '0, 1'b1);
			end
		end
		CMD_DELETE: begin
			if (pos >= list_len) begin
				await_result(ST_REJECT, '0, '0, 1'b1);
			end else begin
				for (i = pos; i + 1 < list_len; i++)
					list_copy[i] = list_copy[i+1];
				list_len--;
				await_result(ST_DONE, '0, '0, 1'b1);
			end
		end
		CMD_UPDATE: begin
			if (pos >= list_len) begin
				await_result(ST_REJECT, '0, '0, 1'b1);
			end else begin
				list_copy[pos] = v;
				await_result(ST_DONE, '0, '0, 1'b1);
			end
		end
		CMD_SEARCH: begin
			for (i = 0; i < list_len; i++)
				if (hit < 0 && list_copy[i] == v)
					hit = i;
			if (hit < 0)
				await_result(ST_MISS, '0, '0, 1'b1);
			else
				await_result(ST_DONE, IDX_W'(hit), list_copy[hit], 1'b1);
		end
		CMD_SORT: begin
			for (i = 0; i < list_len; i++) begin
				for (j = i + 1; j < list_len; j++) begin
					if ($signed(list_copy[j]) < $signed(list_copy[i])) begin
						t            = list_copy[i];
						list_copy[i] = list_copy[j];
						list_copy[j] = t;
					end
				end
			end
			await_result(ST_DONE, '0, '0, 1'b1);
		end
		CMD_READOUT: begin
			if (list_len == 0)
				await_result(ST_EMPTY, '0, '0, 1'b1);
			else
				for (i = 0; i < list_len; i++)
					await_result(ST_ENTRY, IDX_W'(i), list_copy[i], i + 1 == list_len);
		end
		default: await_result(ST_REJECT, '0, '0, 1'b1);
		endcase
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_result();
		res_t want;
		if (awaited_results.size() == 0) begin
			$display("%0t: unexpected result, expected none actual status %h data %h",
				$time, m_tuser, m_tdata);
			fail_count++;
			return;
		end
		want = awaited_results.pop_front();
		result_count++;
		check_field("status", 32'(want.status), 32'(m_tuser));
		check_field("found_index", 32'(want.found_index), 32'(m_tdata[3:0]));
		check_field("entry_value", want.entry_value, m_tdata[35:4]);
		check_field("entry_count", 32'(want.entry_count), 32'(m_tdata[40:36]));
		check_field("padding", '0, 32'(m_tdata[47:41]));
		check_field("last", 32'(want.last), 32'(m_tlast));
	endtask

	// A result is checked before a command taken on the same edge is predicted,
	// since that result can only belong to an earlier command.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_len = '0;
			awaited_results.delete();
			awaited_count = 0;
		end else begin
			if (m_tvalid && m_tready)
				check_result();
			if (s_tvalid && s_tready)
				predict_table_op(s_tuser, s_tdata[4:0], s_tdata[36:5]);
			awaited_count = awaited_results.size();
		end
	end

endmodule

// ===== tb/indexed_array_table_tb.sv =====
// Top of the indexed array table testbench: clock, reset, command stimulus, receiver
// stalls and the verdict. Depends on iat_pkg, the indexed_array_table block and iat_checker.
module indexed_array_table_tb
	import iat_pkg::*;
();

	localparam int PERIOD          = 10;
	localparam int RANDOM_ITEMS    = 256;
	localparam int CALM_ITEMS      = 40;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int STALL_LIMIT     = 4000;
	localparam int DRAIN_CYCLES    = 40;

	// Command codes that the block does not define; they must be rejected.
	localparam logic [2:0] CMD_SPARE_A = 3'd6;
	localparam logic [2:0] CMD_SPARE_B = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // position [4:0], value [36:5], zero [39:37]
	logic [2:0]  s_tuser;   // command [2:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;   // found_index [3:0], entry_value [35:4],
	                        // entry_count [40:36], zero [47:41]
	logic [2:0]  m_tuser;   // status [2:0]
	logic        m_tlast;

	int errors;
	int pending;
	int checked;

	bit calm = 1'b0;
	bit hold_off_req = 1'b0;
	bit hold_off_done = 1'b0;
	int idle_run = 0;
	int commands_sent = 0;
	int full_visits = 0;

	// Rough copy of the list length and of recently inserted values, used only to steer
	// the stimulus towards valid indices and search hits.
	int               list_len = 0;
	logic [VAL_W-1:0] recent [DEPTH];
	int               recent_n = 0;

	always #(PERIOD / 2) clk = ~clk;

	indexed_array_table uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	iat_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.errors   (errors),
		.pending  (pending),
		.checked  (checked)
	);

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_run <= 0;
		else
			idle_run <= idle_run + 1;
		if (idle_run >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, run abandoned", $time, idle_run);
			$display("indexed_array_table_tb: errors");
			$finish;
		end
	end

	function automatic logic [VAL_W-1:0] rand_value();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 3)
			return VAL_W'($urandom_range(0, 16)) - VAL_W'(8);
		if (pick == 3) begin
			case ($urandom_range(0, 3))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return '0;
			default: return '1;
			endcase
		end
		return $urandom();
	endfunction

	// Offers one command and returns once it has been taken.
	task automatic send(logic [2:0] op, logic [POS_W-1:0] pos, logic [VAL_W-1:0] v);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 17);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {3'b000, v, pos};
		do @(posedge clk); while (!s_tready);
		commands_sent++;
		if (op == CMD_INSERT && list_len < DEPTH && pos <= list_len) begin
			list_len++;
			recent[recent_n % DEPTH] = v;
			recent_n++;
		end else if (op == CMD_DELETE && pos < list_len) begin
			list_len--;
		end
	endtask

	initial begin : receiver
		m_tready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_off_req && !hold_off_done) begin
				// Long hold-off so that the output register fills and the input stalls.
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_done = 1'b1;
			end else if (calm || $urandom_range(0, 3) != 0) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end else begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		logic [2:0]       op;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] v;
		int               r;
		bit               grow;
		s_tvalid = 1'b0;
		s_tuser  = '0;
		s_tdata  = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty list: every command but the sort (which reports done) either rejects, misses or reports the empty list.
		send(CMD_READOUT, 0, $urandom());
		send(CMD_DELETE, 0, $urandom());
		send(CMD_UPDATE, 0, $urandom());
		send(CMD_SEARCH, 0, '0);
		send(CMD_SORT, 0, $urandom());
		send(CMD_INSERT, 1, 32'd5);
		// Build -1, min, 0, max through front, append and middle inserts.
		send(CMD_INSERT, 0, 32'h8000_0000);
		send(CMD_INSERT, 1, 32'h7fff_ffff);
		send(CMD_INSERT, 0, 32'hffff_ffff);
		send(CMD_INSERT, 2, 32'h0000_0000);
		send(CMD_SEARCH, 0, 32'h7fff_ffff);
		send(CMD_SEARCH, 0, 32'd12345);
		send(CMD_SEARCH, 0, 32'h8000_0000);
		send(CMD_UPDATE, 3, 32'd5);
		send(CMD_UPDATE, 4, 32'd9);
		send(CMD_INSERT, 5, 32'd9);
		send(CMD_SORT, 0, '0);
		send(CMD_READOUT, 0, '0);
		send(CMD_DELETE, 3, '0);
		send(CMD_DELETE, 0, '0);
		send(CMD_DELETE, 31, '0);
		send(CMD_SPARE_A, 0, $urandom());
		send(CMD_SPARE_B, 31, $urandom());
		send(CMD_READOUT, 0, '0);

		// The mix leans towards inserts until the list is full, then towards deletes
		// until it is empty, so both ends are visited repeatedly.
		grow = 1'b1;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS * 2 / 5)
				hold_off_req = 1'b1;
			if (n >= RANDOM_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			if (list_len == DEPTH && grow) begin
				grow = 1'b0;
				full_visits++;
			end else if (list_len == 0) begin
				grow = 1'b1;
			end
			r   = $urandom_range(0, 99);
			v   = rand_value();
			pos = (list_len == 0) ? '0 : POS_W'($urandom_range(0, list_len - 1));
			if (r < (grow ? 35 : 15)) begin
				op  = CMD_INSERT;
				pos = POS_W'($urandom_range(0, list_len));
			end else if (r < 50) begin
				op = CMD_DELETE;
			end else if (r < 60) begin
				op = CMD_UPDATE;
			end else if (r < 74) begin
				op = CMD_SEARCH;
				if (recent_n > 0 && $urandom_range(0, 2) != 0)
					v = recent[$urandom_range(0, (recent_n < DEPTH ? recent_n : DEPTH) - 1)];
			end else if (r < 82) begin
				op = CMD_SORT;
			end else if (r < 93) begin
				op = CMD_READOUT;
			end else begin
				// Any code, any position: mostly rejects and undefined commands.
				op  = 3'($urandom_range(0, 7));
				pos = POS_W'($urandom_range(0, 31));
			end
			send(op, pos, v);
		end
		s_tvalid <= 1'b0;
		@(posedge clk);

		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d commands and %0d checked results;", commands_sent, checked);
		$display("the list was filled to capacity %0d times and drained to empty between.",
			full_visits);
		if (errors == 0)
			$display("indexed_array_table_tb: clean");
		else
			$display("indexed_array_table_tb: errors");
		$finish;
	end

endmodule
